[rtl/mtfd_pkg.sv]
// Shared types and constants for the move-to-front decoder.
// No dependencies; every other file imports this package.
`default_nettype none

package mtfd_pkg;

  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  // Position compares run at the width of the position field plus one.
  localparam int unsigned CMP_W      = 9;
  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned NUM_GROUPS = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DECODED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                load_en;
    logic                move_en;
    logic [IDX_W-1:0]    load_idx;
    logic [IDX_W-1:0]    pos;
    logic [SYMBOL_W-1:0] load_symbol;
  } mtfd_ctrl_t;

endpackage : mtfd_pkg

`default_nettype wire

[rtl/mtfd_in_if.sv]
// Request channel of the move-to-front decoder: valid/ready plus payload.
// Depends on mtfd_pkg.
`default_nettype none

interface mtfd_in_if
  import mtfd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SYMBOL_W-1:0] load_symbol;
  logic [POS_W-1:0]    position;

  modport source (output valid, output opcode, output load_symbol, output position,
                  input ready);
  modport sink   (input valid, input opcode, input load_symbol, input position,
                  output ready);
endinterface : mtfd_in_if

`default_nettype wire

[rtl/mtfd_out_if.sv]
// Result channel of the move-to-front decoder: valid/ready plus payload.
// Depends on mtfd_pkg.
`default_nettype none

interface mtfd_out_if
  import mtfd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output symbol, output status, input ready);
  modport sink   (input valid, input symbol, input status, output ready);
endinterface : mtfd_out_if

`default_nettype wire

[rtl/move_to_front_decoder_core.sv]
// Inverse move-to-front decoder top: controller, row of list cells, gather tree.
// Depends on mtfd_pkg, mtfd_in_if, mtfd_out_if, mtfd_cell, mtfd_gather.
//
//   channel  | dir | handshake    | payload
//   in_req   | in  | valid/ready  | opcode, load_symbol, position
//   out_rsp  | out | valid/ready  | symbol, status
//
// Clear, append and rejected requests are answered on accept; a decode passes through
// accept, tap gather into the group registers, final OR plus shift of the cell row.
// The two-level gather tree registers its first level; a decode blocks new requests.
// A new request is taken while a result waits, as long as the result is taken
// in the same cycle; otherwise the request waits. Reset empties the list.
`default_nettype none

module move_to_front_decoder_core
  import mtfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtfd_in_if.sink   in_req,
  mtfd_out_if.source out_rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GATHER = 2'd1;
  localparam logic [1:0] S_MOVE   = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  logic [SYMBOL_W-1:0] out_sym_q, out_sym_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic                out_free;
  logic                accept;
  logic                list_full;
  logic                pos_ok;
  logic                move_fire;
  logic [SYMBOL_W-1:0] gathered_sym;
  mtfd_ctrl_t          ctrl;

  logic [SYMBOL_W-1:0] cell_sym [LIST_DEPTH];
  logic [SYMBOL_W-1:0] cell_tap [LIST_DEPTH];

  assign out_free  = !out_valid_q || out_rsp.ready;
  assign in_req.ready = (state_q == S_IDLE) && out_free;
  assign accept    = in_req.valid && in_req.ready;
  assign list_full = (count_q == CNT_W'(LIST_DEPTH));
  assign pos_ok    = CMP_W'(in_req.position) < CMP_W'(count_q);
  assign move_fire = (state_q == S_MOVE) && out_free;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !out_rsp.ready;
    out_sym_d    = out_sym_q;
    out_status_d = out_status_q;

    ctrl.load_en     = 1'b0;
    ctrl.move_en     = 1'b0;
    ctrl.load_idx    = count_q[IDX_W-1:0];
    ctrl.pos         = pos_q;
    ctrl.load_symbol = in_req.load_symbol;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_sym_d = '0;
          if (in_req.opcode == OP_CLEAR) begin
            count_d      = '0;
            out_valid_d  = 1'b1;
            out_status_d = ST_CLEARED;
          end else if (in_req.opcode == OP_LOAD) begin
            out_valid_d = 1'b1;
            if (list_full) begin
              out_status_d = ST_FULL;
            end else begin
              ctrl.load_en = 1'b1;
              count_d      = count_q + 1'b1;
              out_status_d = ST_LOADED;
            end
          end else if ((in_req.opcode == OP_DECODE) && pos_ok) begin
            pos_d   = in_req.position[IDX_W-1:0];
            state_d = S_GATHER;
          end else begin
            // out-of-range decode or unused opcode
            out_valid_d  = 1'b1;
            out_status_d = ST_RANGE;
          end
        end
      end
      S_GATHER: begin
        state_d = S_MOVE;
      end
      S_MOVE: begin
        if (move_fire) begin
          ctrl.move_en = 1'b1;
          out_valid_d  = 1'b1;
          out_sym_d    = gathered_sym;
          out_status_d = ST_DECODED;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    out_sym_q    <= out_sym_d;
    out_status_q <= out_status_d;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [SYMBOL_W-1:0] prev_sym;
    if (i == 0) begin : g_front
      assign prev_sym = gathered_sym;
    end else begin : g_rest
      assign prev_sym = cell_sym[i-1];
    end

    mtfd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(i)),
      .prev_sym_i (prev_sym),
      .sym_o      (cell_sym[i]),
      .tap_o      (cell_tap[i])
    );
  end

  mtfd_gather u_gather (
    .clk_i     (clk_i),
    .capture_i (state_q == S_GATHER),
    .taps_i    (cell_tap),
    .symbol_o  (gathered_sym)
  );

  assign out_rsp.valid  = out_valid_q;
  assign out_rsp.symbol = out_sym_q;
  assign out_rsp.status = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == '0) || (count_q == $past(count_q) + 1'b1)))
    else $error("entry count moved other than by clear or append");

  a_gather_to_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GATHER) |=> (state_q == S_MOVE))
    else $error("gather not followed by move");

  a_move_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (CNT_W'(pos_q) < count_q))
    else $error("move with position outside the list");

endmodule : move_to_front_decoder_core

`default_nettype wire

[rtl/mtfd_cell.sv]
// One list entry: holds a symbol, loads on append, takes its neighbor's
// symbol on a move, and taps its symbol out when selected. Depends on mtfd_pkg.
`default_nettype none

module mtfd_cell
  import mtfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire mtfd_ctrl_t          ctrl_i,
  input  wire logic [IDX_W-1:0]    cell_idx_i,
  input  wire logic [SYMBOL_W-1:0] prev_sym_i,
  output      logic [SYMBOL_W-1:0] sym_o,
  output      logic [SYMBOL_W-1:0] tap_o
);

  logic [SYMBOL_W-1:0] sym_q, sym_d;

  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.load_en && (cell_idx_i == ctrl_i.load_idx)) begin
      sym_d = ctrl_i.load_symbol;
    end else if (ctrl_i.move_en && (cell_idx_i <= ctrl_i.pos)) begin
      // cell 0 receives the decoded symbol, the rest shift back by one
      sym_d = prev_sym_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign sym_o = sym_q;
  assign tap_o = (cell_idx_i == ctrl_i.pos) ? sym_q : '0;

endmodule : mtfd_cell

`default_nettype wire

[rtl/mtfd_gather.sv]
// Registered OR tree that collects the one selected cell tap.
// First level ORs groups of taps into registers. Depends on mtfd_pkg.
`default_nettype none

module mtfd_gather
  import mtfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                capture_i,
  input  wire logic [SYMBOL_W-1:0] taps_i [LIST_DEPTH],
  output      logic [SYMBOL_W-1:0] symbol_o
);

  logic [SYMBOL_W-1:0] grp_q [NUM_GROUPS];
  logic [SYMBOL_W-1:0] grp_d [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < LIST_DEPTH) begin
          grp_d[g] = grp_d[g] | taps_i[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    symbol_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      symbol_o = symbol_o | grp_q[g];
    end
  end

endmodule : mtfd_gather

`default_nettype wire

[bench/tb_move_to_front_decoder_core.sv]
// Self-checking bench for move_to_front_decoder_core: a directed table, then random episodes
// of clear, append and decode requests, each checked against a move-to-front list kept here.
// Depends on mtfd_pkg, mtfd_in_if, mtfd_out_if and the core.
`timescale 1ns / 100ps

module tb_move_to_front_decoder_core;
  import mtfd_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_REQ_TARGET = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  // headroom a fill episode needs so the run stays near the request target
  localparam int FILL_ROOM    = LIST_DEPTH + 64;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [SYMBOL_W-1:0] sym;
    logic [POS_W-1:0]    pos;
    logic                fixed;
    rsp_t                answer;
  } dir_row_t;

  localparam int N_DIR = 21;

  // Rows with fixed set carry a typed answer; the rest go through the list model.
  dir_row_t dir_table [N_DIR] = '{
    '{OP_DECODE, 8'h00, 8'h00, 1'b1, '{8'h00, ST_RANGE}},   // empty list
    '{OP_UNUSED, 8'hFF, 8'hFF, 1'b1, '{8'h00, ST_RANGE}},
    '{OP_LOAD,   8'h00, 8'hFF, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_LOAD,   8'hFF, 8'h00, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_LOAD,   8'h5A, 8'hA5, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_LOAD,   8'hA5, 8'h5A, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_LOAD,   8'h5A, 8'h00, 1'b1, '{8'h00, ST_LOADED}},  // duplicate byte
    '{OP_DECODE, 8'hFF, 8'h00, 1'b0, '{8'h00, ST_DECODED}}, // front, no reorder
    '{OP_DECODE, 8'h00, 8'h04, 1'b0, '{8'h00, ST_DECODED}}, // later copy of 5A
    '{OP_DECODE, 8'h00, 8'h02, 1'b0, '{8'h00, ST_DECODED}},
    '{OP_DECODE, 8'h00, 8'h05, 1'b1, '{8'h00, ST_RANGE}},   // pos == count
    '{OP_DECODE, 8'h00, 8'hFF, 1'b1, '{8'h00, ST_RANGE}},
    '{OP_CLEAR,  8'hFF, 8'hFF, 1'b1, '{8'h00, ST_CLEARED}},
    '{OP_DECODE, 8'hFF, 8'h00, 1'b1, '{8'h00, ST_RANGE}},
    '{OP_LOAD,   8'h80, 8'h7F, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_DECODE, 8'h00, 8'h00, 1'b1, '{8'h80, ST_DECODED}},
    '{OP_UNUSED, 8'h00, 8'h00, 1'b1, '{8'h00, ST_RANGE}},
    '{OP_LOAD,   8'h01, 8'h80, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_LOAD,   8'h7F, 8'h01, 1'b1, '{8'h00, ST_LOADED}},
    '{OP_DECODE, 8'h00, 8'h02, 1'b0, '{8'h00, ST_DECODED}},
    '{OP_DECODE, 8'h00, 8'h01, 1'b0, '{8'h00, ST_DECODED}}
  };

  logic clk_i;
  logic rst_ni;

  mtfd_in_if  in_if ();
  mtfd_out_if out_if ();

  move_to_front_decoder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_if),
    .out_rsp (out_if)
  );

  logic [SYMBOL_W-1:0] mtf_list [LIST_DEPTH];
  int   mtf_len;
  rsp_t symbol_status_q [$];
  int   err_count;
  int   req_sent;
  int   full_fills;
  bit   calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[move_to_front_decoder_core] ERROR");
    $finish;
  end

  // Inverse move-to-front on the local list; returns what the block should answer.
  function automatic rsp_t mtf_apply(logic [OPCODE_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                                     logic [POS_W-1:0] pos);
    rsp_t r;
    logic [SYMBOL_W-1:0] hit;
    r.symbol = '0;
    r.status = ST_RANGE;
    case (op)
      OP_CLEAR: begin
        mtf_len  = 0;
        r.status = ST_CLEARED;
      end
      OP_LOAD: begin
        if (mtf_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mtf_list[mtf_len] = sym;
          mtf_len++;
          r.status = ST_LOADED;
        end
      end
      OP_DECODE: begin
        if (int'(pos) < mtf_len) begin
          hit = mtf_list[pos];
          for (int k = int'(pos); k > 0; k--) mtf_list[k] = mtf_list[k-1];
          mtf_list[0] = hit;
          r.symbol = hit;
          r.status = ST_DECODED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("t=%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_req(logic [OPCODE_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                          logic [POS_W-1:0] pos, bit fixed = 1'b0, rsp_t answer = '0);
    int   gap;
    rsp_t r;
    gap = calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.load_symbol <= sym;
    in_if.position    <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    r = mtf_apply(op, sym, pos);
    symbol_status_q.push_back(fixed ? answer : r);
    req_sent++;
  endtask

  task automatic run_episode(bit fill_up);
    int n_load;
    int n_dec;
    int r;
    logic [POS_W-1:0] p;
    calm = ($urandom_range(0, 3) == 0);
    if (fill_up || $urandom_range(0, 3) != 0) begin
      send_req(OP_CLEAR, SYMBOL_W'($urandom), POS_W'($urandom));
    end
    n_load = fill_up ? LIST_DEPTH - mtf_len + $urandom_range(1, 3) : $urandom_range(1, 24);
    for (int i = 0; i < n_load; i++) begin
      // a small alphabet now and then, so repeated bytes show up in the list
      send_req(OP_LOAD, ($urandom_range(0, 3) == 0) ? SYMBOL_W'($urandom_range(0, 7))
                                                     : SYMBOL_W'($urandom_range(0, 255)),
               POS_W'($urandom));
    end
    if (fill_up) send_req(OP_DECODE, SYMBOL_W'($urandom), 8'hFF);
    n_dec = $urandom_range(4, 40);
    for (int i = 0; i < n_dec; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80 && mtf_len > 0) begin
        case ($urandom_range(0, 3))
          0:       p = POS_W'($urandom_range(0, (mtf_len > 4) ? 3 : mtf_len - 1));
          1:       p = POS_W'(mtf_len - 1);
          default: p = POS_W'($urandom_range(0, mtf_len - 1));
        endcase
        send_req(OP_DECODE, SYMBOL_W'($urandom), p);
      end else if (r < 90) begin
        send_req(OP_DECODE, SYMBOL_W'($urandom), POS_W'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_req(OP_LOAD, SYMBOL_W'($urandom), POS_W'($urandom));
      end else if (r < 98) begin
        send_req(OP_UNUSED, SYMBOL_W'($urandom), POS_W'($urandom));
      end else begin
        send_req(OP_CLEAR, SYMBOL_W'($urandom), POS_W'($urandom));
      end
    end
  endtask

  // Result side: random back-pressure unless in a calm stretch.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        out_if.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (symbol_status_q.size() == 0) begin
        report_mismatch("unexpected response, symbol", out_if.symbol, 8'h00);
      end else begin
        want = symbol_status_q.pop_front();
        if (out_if.symbol !== want.symbol) report_mismatch("symbol", out_if.symbol, want.symbol);
        if (out_if.status !== want.status) begin
          report_mismatch("status", 8'(out_if.status), 8'(want.status));
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_CLEAR;
    in_if.load_symbol = '0;
    in_if.position    = '0;
    out_if.ready      = 1'b0;
    mtf_len           = 0;
    err_count         = 0;
    req_sent          = 0;
    full_fills        = 0;
    calm              = 1'b0;
    foreach (mtf_list[i]) mtf_list[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_table[i]) begin
      send_req(dir_table[i].op, dir_table[i].sym, dir_table[i].pos,
               dir_table[i].fixed, dir_table[i].answer);
    end

    // first episode always fills the list to overflow
    run_episode(1'b1);
    full_fills = 1;
    while (req_sent < N_REQ_TARGET) begin
      if (full_fills < 3 && req_sent + FILL_ROOM < N_REQ_TARGET &&
          $urandom_range(0, 7) == 0) begin
        run_episode(1'b1);
        full_fills++;
      end else begin
        run_episode(1'b0);
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    calm = 1'b1;

    while (symbol_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[move_to_front_decoder_core] OK");
    end else begin
      $display("[move_to_front_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtfd_pkg.sv
rtl/mtfd_in_if.sv
rtl/mtfd_out_if.sv
rtl/mtfd_cell.sv
rtl/mtfd_gather.sv
rtl/move_to_front_decoder_core.sv
bench/tb_move_to_front_decoder_core.sv
